[hw/rtl/pkt_pkg.sv]
package pkt_pkg;

  // Table geometry
  localparam int KEY_SLOTS = 16;
  localparam int IDX_W     = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int CNT_W     = $clog2(KEY_SLOTS + 1);

  // Field widths
  localparam int CMD_W   = 2;
  localparam int CODE_W  = 8;
  localparam int COUNT_W = 5;

  // Command codes; the unused code is handled as a query
  localparam logic [CMD_W-1:0] CMD_KEY_DOWN = 2'd0;
  localparam logic [CMD_W-1:0] CMD_KEY_UP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY    = 2'd2;

  localparam logic [CODE_W-1:0] CODE_EMPTY = 8'd0;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH,
    S_OUT
  } state_t;

endpackage

[hw/rtl/pressed_key_table_unit.sv]
// Sequence: an accepted item is compared with each held slot in turn
//   (S_SCAN), the table and held count are updated (S_FINISH), and the
//   result is held in S_OUT until taken; only then is a new item accepted.
//   The single slot read port, walked once per item, sets the pace.
// Reset: rst is synchronous, active high; it zeroes the held count, leaving
//   the table logically empty (slot storage is not cleared), and drops any item in flight.
module pressed_key_table_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [1:0] command, [9:2] key_code, [15:10] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata   // [0] key_present, [1] event_dropped,
                                     // [6:2] held_count, [7] zero
);

  localparam int IDX_W = pkt_pkg::IDX_W;
  localparam int CNT_W = pkt_pkg::CNT_W;

  pkt_pkg::state_t state, state_next;

  logic [pkt_pkg::CODE_W-1:0] held_codes [pkt_pkg::KEY_SLOTS];
  logic [CNT_W-1:0]           total;
  logic [CNT_W-1:0]           scan_idx;
  logic                       found;
  logic [pkt_pkg::CMD_W-1:0]  cmd_r;
  logic [pkt_pkg::CODE_W-1:0] code_r;
  logic                       present_r;
  logic                       dropped_r;

  logic                       scan_done;
  logic [pkt_pkg::CODE_W-1:0] rd_code;
  logic                       hit;
  logic                       full;
  logic                       code_valid;
  logic                       do_append;
  logic                       do_remove;
  logic                       wr_en;
  logic [IDX_W-1:0]           wr_addr;
  logic [pkt_pkg::CODE_W-1:0] wr_data;

  // Shared compare path: one slot read per scan cycle
  assign scan_done  = (scan_idx == total);
  assign rd_code    = held_codes[scan_idx[IDX_W-1:0]];
  assign code_valid = (code_r != pkt_pkg::CODE_EMPTY);
  assign hit        = !scan_done && !found && code_valid && (rd_code == code_r);
  assign full       = (total == CNT_W'(pkt_pkg::KEY_SLOTS));
  assign do_append  = (cmd_r == pkt_pkg::CMD_KEY_DOWN) && code_valid && !full && !found;
  assign do_remove  = (cmd_r == pkt_pkg::CMD_KEY_UP) && found;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      pkt_pkg::S_IDLE:   if (s_axis_tvalid) state_next = pkt_pkg::S_SCAN;
      pkt_pkg::S_SCAN:   if (scan_done) state_next = pkt_pkg::S_FINISH;
      pkt_pkg::S_FINISH: state_next = pkt_pkg::S_OUT;
      pkt_pkg::S_OUT:    if (m_axis_tready) state_next = pkt_pkg::S_IDLE;
      default:           state_next = pkt_pkg::S_IDLE;
    endcase
  end

  // Handshake and slot write port
  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = rd_code;
    unique case (state)
      pkt_pkg::S_IDLE: s_axis_tready = 1'b1;
      pkt_pkg::S_SCAN: begin
        // after the match, move each later entry down one slot
        if (found && (cmd_r == pkt_pkg::CMD_KEY_UP) && !scan_done) begin
          wr_en   = 1'b1;
          wr_addr = IDX_W'(scan_idx - CNT_W'(1));
          wr_data = rd_code;
        end
      end
      pkt_pkg::S_FINISH: begin
        if (do_append) begin
          wr_en   = 1'b1;
          wr_addr = IDX_W'(total);
          wr_data = code_r;
        end else if (do_remove) begin
          wr_en   = 1'b1;
          wr_addr = IDX_W'(total - CNT_W'(1));
          wr_data = pkt_pkg::CODE_EMPTY;
        end
      end
      pkt_pkg::S_OUT: m_axis_tvalid = 1'b1;
      default: ;
    endcase
  end

  // Slot storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      held_codes[wr_addr] <= wr_data;
    end
  end

  // Sequencer and count
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pkt_pkg::S_IDLE;
      total <= '0;
    end else begin
      state <= state_next;
      if (state == pkt_pkg::S_FINISH) begin
        if (do_append) begin
          total <= total + CNT_W'(1);
        end else if (do_remove) begin
          total <= total - CNT_W'(1);
        end
      end
    end
  end

  // Item capture, scan pointer and result flags
  always_ff @(posedge clk) begin
    unique case (state)
      pkt_pkg::S_IDLE: begin
        cmd_r    <= s_axis_tdata[1:0];
        code_r   <= s_axis_tdata[9:2];
        scan_idx <= '0;
        found    <= 1'b0;
      end
      pkt_pkg::S_SCAN: begin
        if (!scan_done) scan_idx <= scan_idx + CNT_W'(1);
        if (hit) found <= 1'b1;
      end
      pkt_pkg::S_FINISH: begin
        present_r <= found;
        dropped_r <= (cmd_r == pkt_pkg::CMD_KEY_DOWN) && code_valid && full;
      end
      default: ;
    endcase
  end

  assign m_axis_tdata = {1'b0, pkt_pkg::COUNT_W'(total), dropped_r, present_r};

  // Checks
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= CNT_W'(pkt_pkg::KEY_SLOTS))
    else $error("held count above slot count");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input taken while a result is pending");

  a_total_only_on_update: assert property (@(posedge clk) disable iff (rst)
    (state != pkt_pkg::S_FINISH) |=> $stable(total))
    else $error("held count changed outside the update cycle");

  a_drop_means_full: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && dropped_r) |-> (total == CNT_W'(pkt_pkg::KEY_SLOTS)))
    else $error("drop reported with a free slot");

  a_remove_needs_match: assert property (@(posedge clk) disable iff (rst)
    (state == pkt_pkg::S_FINISH && cmd_r == pkt_pkg::CMD_KEY_UP && !found)
      |=> $stable(total))
    else $error("key up of an absent code changed the count");

endmodule

[bench/pressed_key_table_unit_tb.sv]
module pressed_key_table_unit_tb;

  // Unused command code, handled by the block as a query
  localparam logic [pkt_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int RANDOM_EVENTS = 1820;
  localparam int DRAIN_CYCLES  = 40;
  localparam int RUN_LIMIT     = 1_000_000;
  localparam int POOL_SIZE     = 24;

  typedef struct packed {
    logic                        present;
    logic                        dropped;
    logic [pkt_pkg::COUNT_W-1:0] count;
  } key_result_t;

  typedef struct packed {
    logic [pkt_pkg::CMD_W-1:0]  cmd;
    logic [pkt_pkg::CODE_W-1:0] code;
    bit                         has_want;
    key_result_t                want;
  } opening_row_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata = '0;   // [1:0] command, [9:2] key_code, [15:10] zero
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [7:0]        m_axis_tdata;        // [0] key_present, [1] event_dropped,
                                          // [6:2] held_count, [7] zero

  // Bench copy of the held-key list
  logic [pkt_pkg::CODE_W-1:0] held_keys [pkt_pkg::KEY_SLOTS];
  int                held_num = 0;

  key_result_t       expected_results [$];
  bit                failed = 1'b0;
  bit                sender_steady = 1'b0;
  int                cycle_count = 0;

  // Opening sequence: empty-table cases, fill to the limit, refusals, removals
  opening_row_t opening_rows [0:27] = '{
    '{pkt_pkg::CMD_QUERY,    pkt_pkg::CODE_EMPTY, 1'b1, {1'b0, 1'b0, 5'd0}},
    '{pkt_pkg::CMD_KEY_UP,   8'd255,              1'b1, {1'b0, 1'b0, 5'd0}},
    '{pkt_pkg::CMD_KEY_DOWN, pkt_pkg::CODE_EMPTY, 1'b1, {1'b0, 1'b0, 5'd0}},
    '{pkt_pkg::CMD_KEY_DOWN, 8'd255,              1'b1, {1'b0, 1'b0, 5'd1}},
    '{pkt_pkg::CMD_KEY_DOWN, 8'd255,              1'b1, {1'b1, 1'b0, 5'd1}},
    '{pkt_pkg::CMD_QUERY,    8'd255,              1'b1, {1'b1, 1'b0, 5'd1}},
    '{pkt_pkg::CMD_KEY_UP,   pkt_pkg::CODE_EMPTY, 1'b1, {1'b0, 1'b0, 5'd1}},
    '{CMD_UNUSED,            8'd255,              1'b1, {1'b1, 1'b0, 5'd1}},
    '{pkt_pkg::CMD_KEY_DOWN, 8'd1,                1'b0, '0},
    '{pkt_pkg::CMD_KEY_DOWN, 8'd2,                1'b0, '0},
    '{pkt_pkg::CMD_KEY_DOWN, 8'd4,                1'b0, '0},
    '{pkt_pkg::CMD_KEY_DOWN, 8'd8,                1'b0, '0},
    '{pkt_pkg::CMD_KEY_DOWN, 8'd16,               1'b0, '0},
    '{pkt_pkg::CMD_KEY_DOWN, 8'd32,               1'b0, '0},
    '{pkt_pkg::CMD_KEY_DOWN, 8'd64,               1'b0, '0},
    '{pkt_pkg::CMD_KEY_DOWN, 8'd127,              1'b0, '0},
    '{pkt_pkg::CMD_KEY_DOWN, 8'd170,              1'b0, '0},
    '{pkt_pkg::CMD_KEY_DOWN, 8'd85,               1'b0, '0},
    '{pkt_pkg::CMD_KEY_DOWN, 8'd7,                1'b0, '0},
    '{pkt_pkg::CMD_KEY_DOWN, 8'd200,              1'b0, '0},
    '{pkt_pkg::CMD_KEY_DOWN, 8'd13,               1'b0, '0},
    '{pkt_pkg::CMD_KEY_DOWN, 8'd254,              1'b0, '0},
    '{pkt_pkg::CMD_KEY_DOWN, 8'd128,              1'b1, {1'b0, 1'b0, 5'd16}},
    '{pkt_pkg::CMD_KEY_DOWN, 8'd129,              1'b1, {1'b0, 1'b1, 5'd16}},
    '{pkt_pkg::CMD_KEY_DOWN, 8'd255,              1'b1, {1'b1, 1'b1, 5'd16}},
    '{pkt_pkg::CMD_KEY_DOWN, pkt_pkg::CODE_EMPTY, 1'b1, {1'b0, 1'b0, 5'd16}},
    '{pkt_pkg::CMD_KEY_UP,   8'd255,              1'b0, '0},
    '{pkt_pkg::CMD_KEY_UP,   8'd7,                1'b0, '0}
  };

  pressed_key_table_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Abort and report a failure once the run reaches the cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("pressed_key_table_unit_tb failed");
      $finish;
    end
  end

  // Apply one key event to the bench list and return the result it produces
  function automatic key_result_t apply_key_event(input logic [pkt_pkg::CMD_W-1:0] cmd,
                                                  input logic [pkt_pkg::CODE_W-1:0] code);
    int          slot;
    key_result_t res;
    slot = -1;
    if (code != pkt_pkg::CODE_EMPTY) begin
      for (int i = 0; i < held_num; i++) begin
        if (slot < 0 && held_keys[i] == code) slot = i;
      end
    end
    res.present = (slot >= 0);
    res.dropped = 1'b0;
    if (cmd == pkt_pkg::CMD_KEY_DOWN && code != pkt_pkg::CODE_EMPTY) begin
      if (held_num >= pkt_pkg::KEY_SLOTS) begin
        res.dropped = 1'b1;
      end else if (!res.present) begin
        held_keys[held_num] = code;
        held_num++;
      end
    end else if (cmd == pkt_pkg::CMD_KEY_UP && code != pkt_pkg::CODE_EMPTY && res.present) begin
      // close the gap: shift later entries down one slot
      for (int i = slot; i < held_num - 1; i++) held_keys[i] = held_keys[i + 1];
      held_keys[held_num - 1] = pkt_pkg::CODE_EMPTY;
      held_num--;
    end
    res.count = pkt_pkg::COUNT_W'(held_num);
    return res;
  endfunction

  // Offer one item after a random gap; queue its expectation once accepted
  task automatic send_key_event(input logic [pkt_pkg::CMD_W-1:0] cmd,
                                input logic [pkt_pkg::CODE_W-1:0] code,
                                input bit has_want, input key_result_t want);
    int          gap;
    key_result_t predicted;
    if ($urandom_range(0, 24) == 0) sender_steady = !sender_steady;
    gap = sender_steady ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, code, cmd};
    do @(posedge clk); while (!s_axis_tready);
    predicted = apply_key_event(cmd, code);
    expected_results.push_back(has_want ? want : predicted);
  endtask

  // Result side: random stalls, compare each item with the oldest expectation
  initial begin : result_sink
    int          stall;
    bit          steady;
    key_result_t want;
    key_result_t got;
    steady = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 24) == 0) steady = !steady;
      stall = steady ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      got.present = m_axis_tdata[0];
      got.dropped = m_axis_tdata[1];
      got.count   = m_axis_tdata[6:2];
      if (expected_results.size() == 0) begin
        $error("unexpected result item, tdata 0x%02h", m_axis_tdata);
        failed = 1'b1;
      end else begin
        want = expected_results.pop_front();
        if (got.present !== want.present) begin
          $error("key_present: expected %0d, got %0d", want.present, got.present);
          failed = 1'b1;
        end
        if (got.dropped !== want.dropped) begin
          $error("event_dropped: expected %0d, got %0d", want.dropped, got.dropped);
          failed = 1'b1;
        end
        if (got.count !== want.count) begin
          $error("held_count: expected %0d, got %0d", want.count, got.count);
          failed = 1'b1;
        end
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    logic [pkt_pkg::CODE_W-1:0] key_pool [POOL_SIZE];
    logic [pkt_pkg::CMD_W-1:0]  cmd;
    logic [pkt_pkg::CODE_W-1:0] code;
    bit                         press_heavy;
    int                         roll;
    for (int i = 0; i < pkt_pkg::KEY_SLOTS; i++) held_keys[i] = pkt_pkg::CODE_EMPTY;
    press_heavy = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // walk the opening table
    foreach (opening_rows[i]) begin
      send_key_event(opening_rows[i].cmd, opening_rows[i].code,
                     opening_rows[i].has_want, opening_rows[i].want);
    end

    // random events: alternate press-heavy and release-heavy stretches
    for (int n = 0; n < RANDOM_EVENTS; n++) begin
      if (n % 300 == 0) begin
        foreach (key_pool[i]) key_pool[i] = pkt_pkg::CODE_W'($urandom_range(1, 255));
      end
      if (n % 50 == 49) press_heavy = !press_heavy;

      roll = $urandom_range(0, 99);
      if (roll < 3)
        cmd = CMD_UNUSED;
      else if (press_heavy)
        cmd = (roll < 65) ? pkt_pkg::CMD_KEY_DOWN :
              (roll < 85) ? pkt_pkg::CMD_KEY_UP : pkt_pkg::CMD_QUERY;
      else
        cmd = (roll < 25) ? pkt_pkg::CMD_KEY_DOWN :
              (roll < 75) ? pkt_pkg::CMD_KEY_UP : pkt_pkg::CMD_QUERY;

      // favor held codes for releases and queries, a small pool for presses
      roll = $urandom_range(0, 99);
      if (roll < 5)
        code = pkt_pkg::CODE_EMPTY;
      else if (roll < 55 && held_num > 0 && cmd != pkt_pkg::CMD_KEY_DOWN)
        code = held_keys[$urandom_range(0, held_num - 1)];
      else if (roll < 85)
        code = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else
        code = pkt_pkg::CODE_W'($urandom_range(1, 255));

      send_key_event(cmd, code, 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    // drain outstanding results, then watch for stray items
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (!failed) begin
      $display("pressed_key_table_unit_tb passed");
    end else begin
      $display("pressed_key_table_unit_tb failed");
    end
    $finish;
  end

endmodule
